// ----- rtl/core/slid_pkg.sv -----
// Package for the sorted list insert/delete block.
// Holds sizes, operation and status codes, controller state, command and status types, sat_pos.
// No dependencies; every other file of the block imports it.
package slid_pkg;

  localparam int CAPACITY = 8;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 6;
  localparam int ECNT_W   = 7;
  // Counter holds 0..CAPACITY; index addresses 0..CAPACITY-1.
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int POS_MAX  = (1 << POS_W) - 1;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input item and restart the scan
    logic step;    // advance the scan index by one
    logic finish;  // update the list and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_more;  // the entry under the index is still below the value
  } sts_t;

  // Position field saturates when the index does not fit.
  function automatic logic [POS_W-1:0] sat_pos(input logic [CNT_W-1:0] idx);
    logic [CNT_W+POS_W-1:0] ext;
    ext = (CNT_W + POS_W)'(idx);
    if (ext > (CNT_W + POS_W)'(POS_MAX)) begin
      return POS_W'(POS_MAX);
    end
    return ext[POS_W-1:0];
  endfunction

endpackage

// ----- rtl/core/slid_in_if.sv -----
// Input channel of the sorted list block: valid/ready handshake plus item.
// Depends on slid_pkg for field widths.
interface slid_in_if import slid_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// ----- rtl/core/slid_out_if.sv -----
// Result channel of the sorted list block: valid/ready handshake plus result.
// Depends on slid_pkg for field widths.
interface slid_out_if import slid_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [ECNT_W-1:0]   entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input position, input entry_count,
                  output ready);
endinterface

// ----- rtl/core/slid_ctrl.sv -----
// Controller of the sorted list block: sequences accept, scan and update.
// Depends on slid_pkg; drives the datapath through cmd_t and reads sts_t.
module slid_ctrl import slid_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_more) begin
          cmd_o.step = 1'b1;
        end else begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        // Hold the finished item until the result register can take it.
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while a result is pending");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_SCAN))
    else $error("accepted item did not start a scan");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("pending result dropped before its transfer");

endmodule

// ----- rtl/core/slid_dp.sv -----
// Datapath of the sorted list block: entry registers, scan index, count,
// and the result register. Depends on slid_pkg; driven by slid_ctrl.
module slid_dp import slid_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                kind_i,
  input  logic [VALUE_W-1:0]  value_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [POS_W-1:0]    position_o,
  output logic [ECNT_W-1:0]   entry_count_o
);

  logic [VALUE_W-1:0]  entries_q [CAPACITY];
  logic [VALUE_W-1:0]  entries_d [CAPACITY];
  logic [VALUE_W-1:0]  value_q;
  logic                kind_q;
  logic [CNT_W-1:0]    idx_q, cnt_q, cnt_d;
  logic [VALUE_W-1:0]  rd_entry;
  logic                full, empty, in_range, found;
  status_e             res_status;
  logic [POS_W-1:0]    res_pos;
  logic [STATUS_W-1:0] status_q;
  logic [POS_W-1:0]    position_q;
  logic [ECNT_W-1:0]   entry_count_q;

  assign rd_entry = entries_q[idx_q[IDX_W-1:0]];
  assign full     = cnt_q >= CNT_W'(CAPACITY);
  assign empty    = cnt_q == '0;
  assign in_range = idx_q < cnt_q;
  assign found    = in_range && (rd_entry == value_q);

  // A full insert needs no scan; an empty list ends it at once by range.
  assign sts_o.scan_more = in_range && (rd_entry < value_q) &&
                           !((kind_q == KIND_INSERT) && full);

  always_comb begin
    entries_d  = entries_q;
    cnt_d      = cnt_q;
    res_status = ST_NOT_FOUND;
    res_pos    = sat_pos(idx_q);
    if (kind_q == KIND_INSERT) begin
      if (full) begin
        res_status = ST_FULL;
        res_pos    = '0;
      end else begin
        res_status = ST_INSERTED;
        cnt_d      = cnt_q + CNT_W'(1);
        for (int k = 0; k < CAPACITY; k++) begin
          if (CNT_W'(k) == idx_q) begin
            entries_d[k] = value_q;
          end else if (k > 0 && CNT_W'(k) > idx_q) begin
            entries_d[k] = entries_q[(k > 0) ? k - 1 : 0];
          end
        end
      end
    end else begin
      if (empty) begin
        res_status = ST_EMPTY;
        res_pos    = '0;
      end else if (found) begin
        res_status = ST_DELETED;
        cnt_d      = cnt_q - CNT_W'(1);
        for (int k = 0; k < CAPACITY - 1; k++) begin
          if (CNT_W'(k) >= idx_q) begin
            entries_d[k] = entries_q[k + 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (cmd_i.finish) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      value_q <= value_i;
    end
    if (cmd_i.finish) begin
      entries_q     <= entries_d;
      status_q      <= res_status;
      position_q    <= res_pos;
      entry_count_q <= ECNT_W'(cnt_d);
    end
  end

  assign status_o      = status_q;
  assign position_o    = position_q;
  assign entry_count_o = entry_count_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= cnt_q)
    else $error("scan index ran past the stored entries");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && kind_q == KIND_INSERT && !full) |=>
      (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("accepted insert did not grow the list by one");

endmodule

// ----- rtl/core/sorted_list_insert_delete_core.sv -----
// Sorted list insert/delete block: keeps up to CAPACITY 16-bit values in
// ascending order. Input channel in_i carries kind (insert or delete) and
// value; result channel out_o carries status, position and entry_count.
// Both use valid/ready; a transfer happens when valid and ready are high.
// One item is handled at a time. After a transfer on in_i the datapath
// scans the entries one per cycle until the first entry not below the value
// or the end of the list (a full insert does not scan), then updates the
// list with all entries shifting in parallel. in_i is ready again in the
// cycle the result turns valid. A pending result sits in the output
// register while the next item is accepted and scanned; if the receiver
// stalls, that item waits in the update step until the register is free.
// Reset empties the list and clears the result valid flag; stored values
// are not cleared.
module sorted_list_insert_delete_core import slid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  slid_in_if.sink     in_i,
  slid_out_if.source  out_o
);

  cmd_t cmd;
  sts_t sts;

  slid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  slid_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (in_i.kind),
    .value_i       (in_i.value),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (out_o.status),
    .position_o    (out_o.position),
    .entry_count_o (out_o.entry_count)
  );

endmodule

// ----- verif/tb_sorted_list_insert_delete_core.sv -----
// Self-checking testbench for sorted_list_insert_delete_core: a directed table, then
// random insert/delete traffic, each result checked against its typed row or a list model.
// Depends on slid_pkg and the slid_in_if / slid_out_if channel interfaces.
module tb_sorted_list_insert_delete_core import slid_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1880;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    status_e             status;
    logic [POS_W-1:0]    position;
    logic [ECNT_W-1:0]   entry_count;
  } list_result_t;

  typedef struct packed {
    kind_e               kind;
    logic [VALUE_W-1:0]  value;
    bit                  typed;
    list_result_t        want;
  } list_cmd_t;

  localparam list_result_t PREDICTED = '0;

  // Rows with typed set carry their result; the others take it from the list model.
  localparam int DIRECTED_ROWS = 28;
  localparam list_cmd_t DIRECTED [DIRECTED_ROWS] = '{
    '{KIND_DELETE, 16'h1234, 1'b1, '{ST_EMPTY, 6'd0, 7'd0}},
    '{KIND_INSERT, 16'h0000, 1'b1, '{ST_INSERTED, 6'd0, 7'd1}},
    '{KIND_INSERT, 16'hFFFF, 1'b1, '{ST_INSERTED, 6'd1, 7'd2}},
    '{KIND_DELETE, 16'h8000, 1'b0, PREDICTED},
    '{KIND_DELETE, 16'hFFFF, 1'b1, '{ST_DELETED, 6'd1, 7'd1}},
    '{KIND_INSERT, 16'hFFFF, 1'b0, PREDICTED},
    '{KIND_INSERT, 16'h5555, 1'b0, PREDICTED},
    '{KIND_INSERT, 16'hAAAA, 1'b0, PREDICTED},
    '{KIND_INSERT, 16'h5555, 1'b0, PREDICTED},
    '{KIND_INSERT, 16'h0000, 1'b0, PREDICTED},
    '{KIND_INSERT, 16'h8000, 1'b0, PREDICTED},
    '{KIND_INSERT, 16'hFFFF, 1'b0, PREDICTED},
    '{KIND_INSERT, 16'h1234, 1'b1, '{ST_FULL, 6'd0, 7'd8}},
    '{KIND_INSERT, 16'hFFFF, 1'b1, '{ST_FULL, 6'd0, 7'd8}},
    '{KIND_DELETE, 16'h5555, 1'b0, PREDICTED},
    '{KIND_DELETE, 16'h5555, 1'b0, PREDICTED},
    '{KIND_DELETE, 16'h5555, 1'b0, PREDICTED},
    '{KIND_DELETE, 16'h0000, 1'b0, PREDICTED},
    '{KIND_DELETE, 16'hFFFE, 1'b0, PREDICTED},
    '{KIND_DELETE, 16'hFFFF, 1'b0, PREDICTED},
    '{KIND_DELETE, 16'hFFFF, 1'b0, PREDICTED},
    '{KIND_DELETE, 16'h0000, 1'b0, PREDICTED},
    '{KIND_DELETE, 16'h8000, 1'b0, PREDICTED},
    '{KIND_DELETE, 16'hAAAA, 1'b0, PREDICTED},
    '{KIND_INSERT, 16'h0010, 1'b1, '{ST_INSERTED, 6'd0, 7'd1}},
    '{KIND_DELETE, 16'h0020, 1'b0, PREDICTED},
    '{KIND_DELETE, 16'h0010, 1'b1, '{ST_DELETED, 6'd0, 7'd0}},
    '{KIND_DELETE, 16'h0010, 1'b1, '{ST_EMPTY, 6'd0, 7'd0}}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  slid_in_if  in_ch ();
  slid_out_if out_ch ();

  sorted_list_insert_delete_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the stored list and its results still owed by the block.
  logic [VALUE_W-1:0] shadow_list [CAPACITY];
  int unsigned        shadow_count = 0;
  list_result_t       owed_results [$];

  int error_count   = 0;
  bit gaps_enabled  = 1'b1;
  bit hold_request  = 1'b0;

  function automatic list_result_t apply_to_list(kind_e kind, logic [VALUE_W-1:0] value);
    list_result_t res;
    int unsigned  slot;
    slot = 0;
    while (slot < shadow_count && shadow_list[slot] < value) slot++;
    res.entry_count = '0;
    res.position    = '0;
    if (kind == KIND_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        for (int i = shadow_count; i > slot; i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[slot] = value;
        shadow_count++;
        res.status   = ST_INSERTED;
        res.position = POS_W'(slot);
      end
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.position = (slot > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(slot);
      if (slot < shadow_count && shadow_list[slot] == value) begin
        for (int i = slot; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
        shadow_count--;
        res.status = ST_DELETED;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
    res.entry_count = ECNT_W'(shadow_count);
    return res;
  endfunction

  // Deletes mostly target stored values so that the list really shrinks;
  // inserts sometimes repeat a stored value to build up duplicates.
  function automatic logic [VALUE_W-1:0] pick_value(kind_e kind);
    int unsigned        sel;
    int unsigned        at;
    logic [VALUE_W-1:0] value;
    sel   = $urandom_range(0, 99);
    value = VALUE_W'($urandom);
    if (shadow_count != 0) begin
      at = $urandom_range(0, shadow_count - 1);
      if (kind == KIND_DELETE) begin
        if (sel < 65) value = shadow_list[at];
        else if (sel < 80) value = sel[0] ? shadow_list[at] + 1'b1 : shadow_list[at] - 1'b1;
      end else if (sel < 30) begin
        value = shadow_list[at];
      end
    end
    if (sel >= 90) begin
      case (sel % 4)
        0: value = 16'h0000;
        1: value = 16'hFFFF;
        2: value = 16'h0001;
        default: value = 16'hFFFE;
      endcase
    end
    return value;
  endfunction

  task automatic offer_item(input kind_e kind, input logic [VALUE_W-1:0] value,
                            input bit typed, input list_result_t want);
    list_result_t predicted;
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.value <= value;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = apply_to_list(kind, value);
    owed_results.push_back(typed ? want : predicted);
  endtask

  task automatic sender_gap(input int unsigned cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (owed_results.size() != 0);
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : stimulus
    int unsigned insert_pct;
    kind_e       kind;
    in_ch.valid = 1'b0;
    in_ch.kind  = KIND_INSERT;
    in_ch.value = '0;
    do @(posedge clk_i); while (!rst_ni);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      offer_item(DIRECTED[r].kind, DIRECTED[r].value, DIRECTED[r].typed, DIRECTED[r].want);
      if ($urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 13));
    end
    wait_all_results();

    insert_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Blocks of traffic lean toward filling, draining or neither.
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 80;
          1: insert_pct = 25;
          default: insert_pct = 50;
        endcase
      end
      if (n == 600) hold_request = 1'b1;
      if (n == 1200) wait_all_results();
      if (n == RANDOM_ITEMS - 200) gaps_enabled = 1'b0;
      kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_DELETE;
      offer_item(kind, pick_value(kind), 1'b0, PREDICTED);
      if (gaps_enabled && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 13));
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_sorted_list_insert_delete_core: PASS");
    end else begin
      $display("tb_sorted_list_insert_delete_core: FAIL");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold that backs the block up.
  initial begin : result_sink
    out_ch.ready = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (owed_results.size() == 0) begin
        $error("result transfer with no result owed: status %0d", out_ch.status);
        error_count++;
      end else begin
        want = owed_results.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          error_count++;
        end
        if (out_ch.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_ch.position);
          error_count++;
        end
        if (out_ch.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_ch.entry_count);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #20ms;
    $display("tb_sorted_list_insert_delete_core: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/slid_pkg.sv
rtl/core/slid_in_if.sv
rtl/core/slid_out_if.sv
rtl/core/slid_ctrl.sv
rtl/core/slid_dp.sv
rtl/core/sorted_list_insert_delete_core.sv
verif/tb_sorted_list_insert_delete_core.sv
